@@ hw/rtl/sfc_pkg.sv @@
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared widths, constants and types for the range-reduced cubic sine pipeline.
// ----------------------------------------------------------------------------
package sfc_pkg;

  localparam int ANGLE_W = 32;
  localparam int SINE_W  = 32;

  localparam int ANGLE_FRAC_BITS_DEF  = 26;
  localparam int RESULT_FRAC_BITS_DEF = 30;

  // pi, unsigned, 60 fraction bits
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  // reduced angle in [0, pi/2], unsigned with 30 fraction bits
  localparam int X_W = 31;

  // cubic coefficients, unsigned with 30 fraction bits
  localparam int A_W  = 28;
  localparam int B_W  = 25;
  localparam int C_W  = 31;
  localparam int T1_W = 29;

  localparam logic [A_W-1:0] COEF_A = A_W'(139400966);
  localparam logic [B_W-1:0] COEF_B = B_W'(33330682);
  localparam logic [C_W-1:0] COEF_C = C_W'(1077491786);

  localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
  localparam logic [29:0] HALF_Q30 = 30'h2000_0000;

  // beat from range reduction to polynomial stages
  typedef struct packed {
    logic           valid;
    logic           neg;
    logic [X_W-1:0] x;
  } sfc_red_t;

endpackage

@@ hw/rtl/sfc_angle_if.sv @@
// ----------------------------------------------------------------------------
// sfc_angle_if
// Valid/ready channel carrying one fixed-point angle per beat.
// ----------------------------------------------------------------------------
interface sfc_angle_if import sfc_pkg::*;;
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

@@ hw/rtl/sfc_sine_if.sv @@
// ----------------------------------------------------------------------------
// sfc_sine_if
// Valid/ready channel carrying one fixed-point sine value per beat.
// ----------------------------------------------------------------------------
interface sfc_sine_if import sfc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [SINE_W-1:0] sine;

  modport source (output valid, output sine, input ready);
  modport sink   (input valid, input sine, output ready);
endinterface

@@ hw/rtl/sfc_reduce.sv @@
// ----------------------------------------------------------------------------
// sfc_reduce
// Five-stage range reduction: sign fold, modulo 2*pi by reciprocal multiply,
// fold into [0, pi/2] with a sign flag.
// ----------------------------------------------------------------------------
module sfc_reduce import sfc_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [ANGLE_W-1:0] angle,
  output sfc_red_t           red
);

  localparam logic [63:0] HALF_PI_L =
    (PI_Q60 + (64'd1 << (60 - ANGLE_FRAC_BITS))) >> (61 - ANGLE_FRAC_BITS);
  localparam logic [63:0] PI_L =
    (PI_Q60 + (64'd1 << (59 - ANGLE_FRAC_BITS))) >> (60 - ANGLE_FRAC_BITS);
  localparam logic [63:0] TWO_PI_L =
    (PI_Q60 + (64'd1 << (58 - ANGLE_FRAC_BITS))) >> (59 - ANGLE_FRAC_BITS);
  localparam logic [63:0] RECIP_L = (64'd1 << 40) / TWO_PI_L;

  localparam int RECIP_W = $clog2(RECIP_L + 64'd1);
  localparam int P_W     = ANGLE_W + RECIP_W;
  localparam int N_W     = P_W - 40;
  localparam int SHIFT   = 30 - ANGLE_FRAC_BITS;

  localparam logic [31:0]        HALF_PI_A = HALF_PI_L[31:0];
  localparam logic [31:0]        PI_A      = PI_L[31:0];
  localparam logic [31:0]        TWO_PI_A  = TWO_PI_L[31:0];
  localparam logic [RECIP_W-1:0] RECIP     = RECIP_L[RECIP_W-1:0];
  localparam logic [X_W-1:0]     HALF_PI_X = X_W'(HALF_PI_A) << SHIFT;

  logic [4:0] vld;
  logic [3:0] neg;

  logic [31:0]    mag1;
  logic [31:0]    mag2;
  logic [N_W-1:0] n2;
  logic [31:0]    r3;
  logic [31:0]    r4;
  logic           neg5;
  logic [X_W-1:0] x5;

  logic [31:0]      mag_next;
  logic [P_W-1:0]   prod;
  logic [N_W+31:0]  nt;
  logic [31:0]      ra;
  logic [31:0]      r4_next;
  logic             neg4_next;
  logic [31:0]      rb;

  always_comb begin
    // two's complement magnitude, most negative angle gives 2^31 unsigned
    mag_next = angle[ANGLE_W-1] ? (~angle + 32'd1) : angle;
    prod     = P_W'(mag1) * P_W'(RECIP);
    nt       = (N_W+32)'(n2) * (N_W+32)'(TWO_PI_A);
    // reciprocal quotient is floor or floor-1, one correction
    ra       = (r3 >= TWO_PI_A) ? (r3 - TWO_PI_A) : r3;
    if (ra > PI_A) begin
      r4_next   = ra - PI_A;
      neg4_next = ~neg[2];
    end else begin
      r4_next   = ra;
      neg4_next = neg[2];
    end
    rb = (r4 > HALF_PI_A) ? (PI_A - r4) : r4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg[0]    <= angle[ANGLE_W-1];
      mag1      <= mag_next;
      neg[1]    <= neg[0];
      mag2      <= mag1;
      n2        <= prod[P_W-1:40];
      neg[2]    <= neg[1];
      r3        <= mag2 - nt[31:0];
      neg[3]    <= neg4_next;
      r4        <= r4_next;
      neg5      <= neg[3];
      x5        <= X_W'(rb) << SHIFT;
    end
  end

  assign red = '{valid: vld[4], neg: neg5, x: x5};

`ifndef SYNTHESIS
  a_mod_turn: assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> (ra < TWO_PI_A))
    else $error("remainder not below 2*pi after correction");

  a_fold_pi: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> (r4 <= PI_A))
    else $error("remainder above pi after fold");

  a_fold_half: assert property (@(posedge clk) disable iff (rst)
    vld[4] |-> (red.x <= HALF_PI_X))
    else $error("reduced angle above pi/2");
`endif

endmodule

@@ hw/rtl/sfc_poly.sv @@
// ----------------------------------------------------------------------------
// sfc_poly
// Seven-stage Horner evaluation of the cubic, rounding, clamp, output scaling
// and sign application.
// ----------------------------------------------------------------------------
module sfc_poly import sfc_pkg::*; #(
  parameter int RESULT_FRAC_BITS = RESULT_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  sfc_red_t          red,
  output logic              valid,
  output logic [SINE_W-1:0] sine
);

  localparam int AX_W  = A_W + X_W;
  localparam int P1_W  = T1_W + X_W;
  localparam int Y_W   = C_W + X_W;
  localparam int SHIFT = 30 - RESULT_FRAC_BITS;

  localparam logic [31:0] HALF_R = (32'd1 << SHIFT) >> 1;
  localparam logic [31:0] ONE_R  = 32'd1 << RESULT_FRAC_BITS;

  logic [6:0] vld;
  logic [5:0] neg;

  logic [AX_W-1:0] ax6;
  logic [X_W-1:0]  x6;
  logic [T1_W-1:0] t1;
  logic [X_W-1:0]  x7;
  logic [P1_W-1:0] p1;
  logic [X_W-1:0]  x8;
  logic [C_W-1:0]  t2;
  logic [X_W-1:0]  x9;
  logic [Y_W-1:0]  y10;
  logic [30:0]     y11;

  logic [AX_W:0]   ax_rnd;
  logic [P1_W:0]   p1_rnd;
  logic [30:0]     pr;
  logic [C_W-1:0]  t2_next;
  logic [Y_W:0]    y_rnd;
  logic [32:0]     yr;
  logic [30:0]     y11_next;
  logic [31:0]     ys;
  logic [31:0]     sine_next;

  always_comb begin
    ax_rnd    = (AX_W+1)'(ax6) + (AX_W+1)'(HALF_Q30);
    p1_rnd    = (P1_W+1)'(p1) + (P1_W+1)'(HALF_Q30);
    pr        = p1_rnd[60:30];
    // -a*x*x - b*x + c never goes below zero on [0, pi/2], saturate anyway
    t2_next   = (pr >= COEF_C) ? '0 : (COEF_C - pr);
    y_rnd     = (Y_W+1)'(y10) + (Y_W+1)'(HALF_Q30);
    yr        = y_rnd[Y_W:30];
    y11_next  = (yr > 33'(ONE_Q30)) ? ONE_Q30 : yr[30:0];
    ys        = (32'(y11) + HALF_R) >> SHIFT;
    sine_next = neg[5] ? (32'd0 - ys) : ys;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:0], red.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg  <= {neg[4:0], red.neg};
      ax6  <= AX_W'(COEF_A) * AX_W'(red.x);
      x6   <= red.x;
      t1   <= T1_W'(ax_rnd[AX_W:30]) + T1_W'(COEF_B);
      x7   <= x6;
      p1   <= P1_W'(t1) * P1_W'(x7);
      x8   <= x7;
      t2   <= t2_next;
      x9   <= x8;
      y10  <= Y_W'(t2) * Y_W'(x9);
      y11  <= y11_next;
      sine <= sine_next;
    end
  end

  assign valid = vld[6];

`ifndef SYNTHESIS
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    vld[5] |-> (y11 <= ONE_Q30))
    else $error("magnitude above one after clamp");

  a_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> ($signed(sine) <= $signed(ONE_R) && $signed(sine) >= -$signed(ONE_R)))
    else $error("sine outside [-1, 1]");

  a_known: assert property (@(posedge clk) disable iff (rst)
    valid |-> !$isunknown(sine))
    else $error("unknown sine on a valid beat");
`endif

endmodule

@@ hw/rtl/fast_sine_range_reduced_cubic_unit.sv @@
// ----------------------------------------------------------------------------
// fast_sine_range_reduced_cubic_unit
// Pipelined sine of a fixed-point angle: range reduction into [0, pi/2] and a
// cubic polynomial in Horner form.
// ----------------------------------------------------------------------------
//  channel     dir  payload                     beat
//  angle_bus   in   angle  s32, ANGLE_FRAC_BITS  one angle
//  sine_bus    out  sine   s32, RESULT_FRAC_BITS one sine value
//
//  one beat in and one beat out per cycle while the output is not held;
//  twelve register stages; the depth is set
//  by five multiplies, each in its own stage, and the compare/round steps
//  the whole pipeline advances together; a held output freezes every stage
//  and angle_bus.ready follows, so nothing is dropped or repeated
//  synchronous reset clears only the stage valid bits
// ----------------------------------------------------------------------------
module fast_sine_range_reduced_cubic_unit import sfc_pkg::*; #(
  parameter int ANGLE_FRAC_BITS  = ANGLE_FRAC_BITS_DEF,
  parameter int RESULT_FRAC_BITS = RESULT_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  sfc_angle_if.sink   angle_bus,
  sfc_sine_if.source  sine_bus
);

  sfc_red_t red;
  logic     en;
  logic     out_valid;

  // advance whenever the output register is empty or being taken
  assign en              = ~out_valid | sine_bus.ready;
  assign angle_bus.ready = en;
  assign sine_bus.valid  = out_valid;

  sfc_reduce #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_reduce (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (angle_bus.valid),
    .angle    (angle_bus.angle),
    .red      (red)
  );

  sfc_poly #(
    .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
  ) u_poly (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .red   (red),
    .valid (out_valid),
    .sine  (sine_bus.sine)
  );

endmodule
